### sv/jvm_pkg.sv
// Shared constants, register indexes and state type for the joystick velocity mapper.
package jvm_pkg;

    localparam int AXIS_CNT    = 8;
    localparam int BUTTON_CNT  = 16;
    localparam int AXIS_IW     = (AXIS_CNT > 1) ? $clog2(AXIS_CNT) : 1;
    localparam int BTN_IW      = (BUTTON_CNT > 1) ? $clog2(BUTTON_CNT) : 1;

    localparam int VAL_W  = 16;   // raw axis value
    localparam int MAG_W  = 15;   // magnitude, deadzone, quotient
    localparam int GAIN_W = 16;   // Q8.8 gain
    localparam int VEL_W  = 23;   // velocity result
    localparam int PROD_W = 32;   // dz times gain
    localparam int NUM_W  = 2 * MAG_W;
    localparam int STEP_W = $clog2(MAG_W);
    localparam int AMAP_W = 3;    // width of one axis index in the axis map

    localparam logic [MAG_W-1:0] FULL_SCALE = 15'h7FFF;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_DEADZONE       = 3'd0,
        REG_LINEAR_SCALE   = 3'd1,
        REG_ANGULAR_SCALE  = 3'd2,
        REG_AXIS_MAP       = 3'd3,
        REG_DEADMAN_BUTTON = 3'd4,
        REG_AUTOREPEAT     = 3'd5
    } t_reg_idx;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;
    localparam logic KIND_AXIS   = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_PUSH
    } t_state;

endpackage

### sv/jvm_if.sv
// Handshake channel interfaces for joystick items and velocity results.
interface jvm_cmd_if import jvm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic                    event_kind;
    logic [7:0]              event_number;
    logic signed [VAL_W-1:0] event_value;

    modport source (output valid, command, event_kind, event_number, event_value,
                    input ready);
    modport sink   (input valid, command, event_kind, event_number, event_value,
                    output ready);
endinterface

interface jvm_vel_if import jvm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] linear_x;
    logic signed [VEL_W-1:0] linear_y;
    logic signed [VEL_W-1:0] linear_z;
    logic signed [VEL_W-1:0] angular_z;
    logic                    deadman_active;

    modport source (output valid, linear_x, linear_y, linear_z, angular_z, deadman_active,
                    input ready);
    modport sink   (input valid, linear_x, linear_y, linear_z, angular_z, deadman_active,
                    output ready);
endinterface

### sv/joystick_to_velocity_mapper.sv
// Joystick to velocity mapper: axis/button store, deadzone rescale, gain, dead-man gate.
// Events leave the block idle; ready stays high in idle, also while a result waits.
// A tick that emits with the dead-man button held runs four axes through one shared
// restoring divider and one 16x16 multiplier, skipping the divider for an axis inside
// the deadzone or a full-scale deadzone, and loads the output register once it is free.
// A dead-man inactive tick pushes a zero result; ready is low until it is registered.
// Synchronous active-low reset loads register defaults and clears stores and fresh flag.
module joystick_to_velocity_mapper import jvm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    jvm_cmd_if.sink            i_cmd,
    jvm_vel_if.source          o_vel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // configuration
    logic [MAG_W-1:0]         r_deadzone;
    logic signed [GAIN_W-1:0] r_lin_scale;
    logic signed [GAIN_W-1:0] r_ang_scale;
    logic [4*AMAP_W-1:0]      r_axis_map;
    logic signed [4:0]        r_deadman;
    logic                     r_autorepeat;

    // joystick state
    logic signed [VAL_W-1:0]  r_axis_store [AXIS_CNT];
    logic [BUTTON_CNT-1:0]    r_buttons;
    logic                     r_fresh;

    // sequencer and shared unit
    t_state                   r_state, n_state;
    logic [1:0]               r_axis;
    logic [STEP_W-1:0]        r_step;
    logic [MAG_W-1:0]         r_den;
    logic [MAG_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_lo;
    logic [MAG_W-1:0]         r_q;
    logic                     r_neg;
    logic signed [PROD_W-1:0] r_prod;
    logic [VEL_W-1:0]         r_res [4];
    logic                     r_active;

    // output register
    logic                     r_out_valid;
    logic [VEL_W-1:0]         r_o_lin_x, r_o_lin_y, r_o_lin_z, r_o_ang_z;
    logic                     r_o_deadman;

    logic                     cfg_wr;
    logic [2:0]               cfg_idx;
    logic                     in_acc;
    logic                     is_tick;
    logic                     emit;
    logic                     dm_active;
    logic                     out_free;
    logic [AMAP_W-1:0]        sel_idx;
    logic signed [VAL_W-1:0]  sel_val;
    logic [VAL_W-1:0]         sel_abs;
    logic [MAG_W-1:0]         sel_mag;
    logic [MAG_W-1:0]         diff;
    logic [NUM_W-1:0]         num;
    logic                     skip_div;
    logic [MAG_W:0]           div_t;
    logic                     div_ge;
    logic [MAG_W-1:0]         n_rem;
    logic signed [VAL_W-1:0]  dz;
    logic signed [GAIN_W-1:0] gain;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [PROD_W-1:0] vel;
    logic                     neg_out;
    logic signed [VAL_W-1:0]  clamp_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        unique case (cfg_idx)
            REG_DEADZONE:       prdata = PDATA_W'(r_deadzone);
            REG_LINEAR_SCALE:   prdata = PDATA_W'($unsigned(r_lin_scale));
            REG_ANGULAR_SCALE:  prdata = PDATA_W'($unsigned(r_ang_scale));
            REG_AXIS_MAP:       prdata = PDATA_W'(r_axis_map);
            REG_DEADMAN_BUTTON: prdata = PDATA_W'($unsigned(r_deadman));
            REG_AUTOREPEAT:     prdata = PDATA_W'(r_autorepeat);
            default:            prdata = '0;
        endcase
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign is_tick     = (i_cmd.command == CMD_TICK);
    assign emit        = r_fresh || r_autorepeat;
    assign dm_active   = !r_deadman[4] && (32'(r_deadman) < BUTTON_CNT) &&
                         r_buttons[r_deadman[BTN_IW-1:0]];
    assign out_free    = !r_out_valid || o_vel.ready;

    assign o_vel.valid          = r_out_valid;
    assign o_vel.linear_x       = r_o_lin_x;
    assign o_vel.linear_y       = r_o_lin_y;
    assign o_vel.linear_z       = r_o_lin_z;
    assign o_vel.angular_z      = r_o_ang_z;
    assign o_vel.deadman_active = r_o_deadman;

    // pick the mapped axis: y, x, yaw, throttle in sequence
    always_comb begin
        case (r_axis)
            2'd0:    sel_idx = r_axis_map[0*AMAP_W +: AMAP_W];
            2'd1:    sel_idx = r_axis_map[1*AMAP_W +: AMAP_W];
            2'd2:    sel_idx = r_axis_map[2*AMAP_W +: AMAP_W];
            default: sel_idx = r_axis_map[3*AMAP_W +: AMAP_W];
        endcase
    end

    always_comb begin
        sel_val  = (32'(sel_idx) < AXIS_CNT) ? r_axis_store[sel_idx[AXIS_IW-1:0]] : '0;
        sel_abs  = sel_val[VAL_W-1] ? VAL_W'(-sel_val) : sel_val;
        sel_mag  = sel_abs[MAG_W-1:0];
        diff     = sel_mag - r_deadzone;
        // (|v| - d) * 32767 as a shift and subtract
        num      = {diff, MAG_W'(0)} - {MAG_W'(0), diff};
        skip_div = (sel_mag < r_deadzone) || (r_deadzone == FULL_SCALE);
    end

    // one restoring division step per cycle
    always_comb begin
        div_t  = {r_rem, r_lo[MAG_W-1]};
        div_ge = div_t >= {1'b0, r_den};
        n_rem  = div_ge ? MAG_W'(div_t - {1'b0, r_den}) : div_t[MAG_W-1:0];
    end

    always_comb begin
        dz       = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        gain     = (r_axis == 2'd2) ? r_ang_scale : r_lin_scale;
        // divide by 256 toward zero
        prod_adj = r_prod + (r_prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        prod_sh  = prod_adj >>> 8;
        neg_out  = (r_axis == 2'd1) || (r_axis == 2'd2);
        vel      = neg_out ? -prod_sh : prod_sh;
    end

    assign clamp_val = (i_cmd.event_value == {1'b1, {(VAL_W-1){1'b0}}}) ?
                       -$signed({1'b0, FULL_SCALE}) : i_cmd.event_value;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_tick && emit) begin
                    n_state = dm_active ? S_LOAD : S_PUSH;
                end
            end
            S_LOAD:  n_state = skip_div ? S_MUL : S_DIV;
            S_DIV:   n_state = (r_step == STEP_W'(MAG_W - 1)) ? S_MUL : S_DIV;
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = (r_axis == 2'd3) ? S_PUSH : S_LOAD;
            S_PUSH:  n_state = out_free ? S_IDLE : S_PUSH;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone   <= 15'd1638;
            r_lin_scale  <= 16'sd256;
            r_ang_scale  <= 16'sd256;
            r_axis_map   <= 12'd1672;
            r_deadman    <= 5'sd0;
            r_autorepeat <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEADZONE:       r_deadzone   <= pwdata[MAG_W-1:0];
                REG_LINEAR_SCALE:   r_lin_scale  <= $signed(pwdata[GAIN_W-1:0]);
                REG_ANGULAR_SCALE:  r_ang_scale  <= $signed(pwdata[GAIN_W-1:0]);
                REG_AXIS_MAP:       r_axis_map   <= pwdata[4*AMAP_W-1:0];
                REG_DEADMAN_BUTTON: r_deadman    <= $signed(pwdata[4:0]);
                REG_AUTOREPEAT:     r_autorepeat <= pwdata[0];
                default: ;
            endcase
        end
    end

    // joystick state and fresh flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_CNT; i++) begin
                r_axis_store[i] <= '0;
            end
            r_buttons <= '0;
            r_fresh   <= 1'b0;
        end else if (in_acc) begin
            if (is_tick) begin
                if (emit) begin
                    r_fresh <= 1'b0;
                end
            end else if (i_cmd.event_kind == KIND_AXIS) begin
                if (32'(i_cmd.event_number) < AXIS_CNT) begin
                    r_axis_store[i_cmd.event_number[AXIS_IW-1:0]] <= clamp_val;
                    r_fresh <= 1'b1;
                end
            end else begin
                if (32'(i_cmd.event_number) < BUTTON_CNT) begin
                    r_buttons[i_cmd.event_number[BTN_IW-1:0]] <= (i_cmd.event_value != '0);
                    r_fresh <= 1'b1;
                end
            end
        end
    end

    // shared datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_axis   <= 2'd0;
                r_active <= dm_active;
                if (!dm_active) begin
                    for (int k = 0; k < 4; k++) begin
                        r_res[k] <= '0;
                    end
                end
            end
            S_LOAD: begin
                r_step <= '0;
                r_q    <= '0;
                r_neg  <= sel_val[VAL_W-1];
                r_den  <= FULL_SCALE - r_deadzone;
                r_rem  <= num[NUM_W-1:MAG_W];
                r_lo   <= num[MAG_W-1:0];
            end
            S_DIV: begin
                r_rem  <= n_rem;
                r_lo   <= {r_lo[MAG_W-2:0], 1'b0};
                r_q    <= {r_q[MAG_W-2:0], div_ge};
                r_step <= r_step + STEP_W'(1);
            end
            S_MUL: begin
                r_prod <= PROD_W'(dz * gain);
            end
            S_SCALE: begin
                r_res[r_axis] <= vel[VEL_W-1:0];
                r_axis        <= r_axis + 2'd1;
            end
            S_PUSH: ;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_vel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && out_free) begin
            r_o_lin_y   <= r_res[0];
            r_o_lin_x   <= r_res[1];
            r_o_ang_z   <= r_res[2];
            r_o_lin_z   <= r_res[3];
            r_o_deadman <= r_active;
        end
    end

endmodule

### verif/tb_joystick_to_velocity_mapper.sv
// Testbench for joystick_to_velocity_mapper: directed table plus random phases against a predictor.
module tb_joystick_to_velocity_mapper;
    import jvm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;   // longer than the longest tick
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 154;

    typedef struct {
        logic                    command;
        logic                    event_kind;
        logic [7:0]              event_number;
        logic signed [VAL_W-1:0] event_value;
    } t_cmd;

    typedef struct {
        logic signed [VEL_W-1:0] linear_x;
        logic signed [VEL_W-1:0] linear_y;
        logic signed [VEL_W-1:0] linear_z;
        logic signed [VEL_W-1:0] angular_z;
        logic                    deadman_active;
    } t_vel;

    typedef struct {
        bit          is_reg;
        t_reg_idx    reg_idx;
        logic [31:0] reg_val;
        t_cmd        item;
        bit          typed;
        bit          emit;
        t_vel        exp;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    jvm_cmd_if cmd_ch ();
    jvm_vel_if vel_ch ();

    joystick_to_velocity_mapper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_vel   (vel_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and register copy
    int                     axis_pos [AXIS_CNT];
    bit [BUTTON_CNT-1:0]    btn_held;
    bit                     fresh_pending;
    logic [MAG_W-1:0]       cfg_deadzone;
    int                     cfg_lin_gain;
    int                     cfg_ang_gain;
    logic [11:0]            cfg_axis_map;
    int                     cfg_deadman;
    bit                     cfg_autorepeat;

    t_vel vel_expected [$];
    int   error_cnt = 0;
    int   cycle_cnt = 0;
    bit   idle_en = 1'b1;
    bit   long_hold_req = 1'b0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic string vel_str(input t_vel v);
        return $sformatf("lx=%0d ly=%0d lz=%0d az=%0d dm=%0b", v.linear_x, v.linear_y,
                         v.linear_z, v.angular_z, v.deadman_active);
    endfunction

    task automatic note_error(input string msg);
        error_cnt++;
        if (error_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    function automatic int deadzone_rescale(input logic [AMAP_W-1:0] idx);
        int     v;
        int     a;
        int     d;
        int     den;
        longint q;
        if (idx >= AXIS_CNT) return 0;
        v = axis_pos[idx];
        a = (v < 0) ? -v : v;
        d = int'(cfg_deadzone);
        if (a < d) return 0;
        den = int'(FULL_SCALE) - d;
        if (den <= 0) return 0;
        q = (longint'(a - d) * int'(FULL_SCALE)) / den;
        return (v > 0) ? int'(q) : -int'(q);
    endfunction

    function automatic logic signed [VEL_W-1:0] apply_gain(input int v, input int gain,
                                                           input bit negate);
        longint p;
        p = (longint'(v) * gain) / 256;   // truncates toward zero
        if (negate) p = -p;
        return p[VEL_W-1:0];
    endfunction

    // Advance the model by one item; return 1 when the item yields a velocity result.
    function automatic bit predict_velocity(input t_cmd it, output t_vel r);
        int v;
        bit held;
        r = '{default: '0};
        if (it.command == CMD_EVENT) begin
            if (it.event_kind == KIND_AXIS) begin
                if (it.event_number < AXIS_CNT) begin
                    v = it.event_value;
                    if (v < -int'(FULL_SCALE)) v = -int'(FULL_SCALE);
                    axis_pos[it.event_number[AXIS_IW-1:0]] = v;
                    fresh_pending = 1'b1;
                end
            end else if (it.event_number < BUTTON_CNT) begin
                btn_held[it.event_number[BTN_IW-1:0]] = (it.event_value != 0);
                fresh_pending = 1'b1;
            end
            return 1'b0;
        end
        if (!fresh_pending && !cfg_autorepeat) return 1'b0;
        fresh_pending = 1'b0;
        held = (cfg_deadman >= 0) && (cfg_deadman < BUTTON_CNT) && btn_held[cfg_deadman];
        if (held) begin
            r.linear_x  = apply_gain(deadzone_rescale(cfg_axis_map[5:3]), cfg_lin_gain, 1'b1);
            r.linear_y  = apply_gain(deadzone_rescale(cfg_axis_map[2:0]), cfg_lin_gain, 1'b0);
            r.linear_z  = apply_gain(deadzone_rescale(cfg_axis_map[11:9]), cfg_lin_gain, 1'b0);
            r.angular_z = apply_gain(deadzone_rescale(cfg_axis_map[8:6]), cfg_ang_gain, 1'b1);
            r.deadman_active = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DEADZONE:       cfg_deadzone   = value[MAG_W-1:0];
            REG_LINEAR_SCALE:   cfg_lin_gain   = int'($signed(value[GAIN_W-1:0]));
            REG_ANGULAR_SCALE:  cfg_ang_gain   = int'($signed(value[GAIN_W-1:0]));
            REG_AXIS_MAP:       cfg_axis_map   = value[11:0];
            REG_DEADMAN_BUTTON: cfg_deadman    = int'($signed(value[4:0]));
            REG_AUTOREPEAT:     cfg_autorepeat = value[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Hold the input until every expected result is back, then let the block settle.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (vel_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic drive_item(input t_cmd it, input bit typed, input bit typed_emit,
                              input t_vel typed_exp);
        t_vel pred;
        bit   emit;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= it.command;
        cmd_ch.event_kind   <= it.event_kind;
        cmd_ch.event_number <= it.event_number;
        cmd_ch.event_value  <= it.event_value;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        emit = predict_velocity(it, pred);
        if (typed) begin
            emit = typed_emit;
            pred = typed_exp;
        end
        if (emit) vel_expected.push_back(pred);
    endtask

    function automatic t_cmd random_item();
        t_cmd it;
        int   sel;
        int   near;
        it.command      = CMD_EVENT;
        it.event_kind   = 1'($urandom_range(0, 1));
        it.event_number = 8'($urandom);
        it.event_value  = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            it.command = CMD_TICK;
        end else if (sel < 75) begin
            it.event_kind   = KIND_AXIS;
            it.event_number = 8'($urandom_range(0, AXIS_CNT - 1));
            case ($urandom_range(0, 5))
                0: it.event_value = 16'sh8000;
                1: it.event_value = 16'sh7FFF;
                2: it.event_value = 16'sh8001;
                3: begin
                    // land on the deadzone edge
                    near = int'(cfg_deadzone) + int'($urandom_range(0, 2)) - 1;
                    it.event_value = ($urandom_range(0, 1) != 0) ? 16'(near) : 16'(-near);
                end
                default: ;
            endcase
        end else if (sel < 92) begin
            it.event_kind = KIND_BUTTON;
            if ($urandom_range(0, 9) < 4 && cfg_deadman >= 0)
                it.event_number = 8'(cfg_deadman);
            else
                it.event_number = 8'($urandom_range(0, BUTTON_CNT - 1));
            if ($urandom_range(0, 9) < 3) it.event_value = '0;
        end
        return it;
    endfunction

    function automatic t_stim_row item_row(input logic cmd, input logic kind,
                                           input logic [7:0] num,
                                           input logic signed [VAL_W-1:0] val);
        t_stim_row r;
        r.is_reg = 1'b0;
        r.item   = '{cmd, kind, num, val};
        r.typed  = 1'b0;
        r.emit   = 1'b0;
        return r;
    endfunction

    function automatic t_stim_row typed_row(input logic cmd, input logic kind,
                                            input logic [7:0] num,
                                            input logic signed [VAL_W-1:0] val,
                                            input bit emit, input int lx, input int ly,
                                            input int lz, input int az, input bit dm);
        t_stim_row r;
        r       = item_row(cmd, kind, num, val);
        r.typed = 1'b1;
        r.emit  = emit;
        r.exp   = '{VEL_W'(lx), VEL_W'(ly), VEL_W'(lz), VEL_W'(az), dm};
        return r;
    endfunction

    function automatic t_stim_row reg_row(input t_reg_idx idx, input logic [31:0] value);
        t_stim_row r;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = value;
        return r;
    endfunction

    // Receiver: random back-pressure bursts and one long hold-off on request
    initial begin
        vel_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        vel_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                vel_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                vel_ch.ready <= 1'b1;
                long_hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                vel_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                vel_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_vel got;
        t_vel want;
        if (i_rst_n && vel_ch.valid === 1'b1 && vel_ch.ready === 1'b1) begin
            got = '{vel_ch.linear_x, vel_ch.linear_y, vel_ch.linear_z, vel_ch.angular_z,
                    vel_ch.deadman_active};
            if (vel_expected.size() == 0) begin
                note_error({"unexpected result ", vel_str(got)});
            end else begin
                want = vel_expected.pop_front();
                if (got.linear_x !== want.linear_x || got.linear_y !== want.linear_y ||
                    got.linear_z !== want.linear_z || got.angular_z !== want.angular_z ||
                    got.deadman_active !== want.deadman_active)
                    note_error({"expected ", vel_str(want), " got ", vel_str(got)});
            end
        end
    end

    initial begin
        t_stim_row   directed_rows [$];
        t_cmd        it;
        t_vel        unused_exp;
        logic [31:0] dz_v;
        logic [31:0] lin_v;
        logic [31:0] ang_v;
        logic [31:0] map_v;
        logic [31:0] dm_v;
        logic [31:0] ar_v;

        i_rst_n             = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = CMD_EVENT;
        cmd_ch.event_kind   = KIND_AXIS;
        cmd_ch.event_number = '0;
        cmd_ch.event_value  = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        unused_exp          = '{default: '0};

        cfg_deadzone   = 15'd1638;
        cfg_lin_gain   = 256;
        cfg_ang_gain   = 256;
        cfg_axis_map   = 12'd1672;
        cfg_deadman    = 0;
        cfg_autorepeat = 1'b1;
        foreach (axis_pos[i]) axis_pos[i] = 0;
        btn_held      = '0;
        fresh_pending = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset state, clamping, deadzone edges, ignored indexes, register extremes
        directed_rows.push_back(typed_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd0, 16'sh8000));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd1, 16'sh7FFF));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd2, 16'sd1637));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd3, 16'sd1638));
        directed_rows.push_back(typed_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_BUTTON, 8'd0, 16'sh0100));
        directed_rows.push_back(typed_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0,
                                          1, -32767, -32767, 0, 0, 1));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd8, 16'sd1000));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_BUTTON, 8'd16, 16'sd1));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd255, -16'sd1));
        directed_rows.push_back(reg_row(REG_AUTOREPEAT, 32'd0));
        directed_rows.push_back(typed_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_BUTTON, 8'd1, 16'sd0));
        directed_rows.push_back(item_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0));
        directed_rows.push_back(typed_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd4, 16'sd12345));
        directed_rows.push_back(item_row(CMD_TICK, KIND_BUTTON, 8'd0, 16'sd0));
        directed_rows.push_back(reg_row(REG_DEADZONE, 32'd32767));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd7, 16'sh8000));
        directed_rows.push_back(typed_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0, 1, 0, 0, 0, 0, 1));
        directed_rows.push_back(reg_row(REG_DEADZONE, 32'd0));
        directed_rows.push_back(reg_row(REG_LINEAR_SCALE, 32'h0000_8000));
        directed_rows.push_back(reg_row(REG_ANGULAR_SCALE, 32'h0000_7FFF));
        directed_rows.push_back(reg_row(REG_AXIS_MAP, 32'h0000_0FFF));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_AXIS, 8'd6, 16'sh7FFF));
        directed_rows.push_back(item_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0));
        directed_rows.push_back(reg_row(REG_DEADMAN_BUTTON, 32'h0000_001F));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_BUTTON, 8'd0, 16'sd1));
        directed_rows.push_back(typed_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(reg_row(REG_DEADMAN_BUTTON, 32'd15));
        directed_rows.push_back(item_row(CMD_EVENT, KIND_BUTTON, 8'd15, 16'shFFFF));
        directed_rows.push_back(item_row(CMD_TICK, KIND_AXIS, 8'd0, 16'sd0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_reg) begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                drive_item(directed_rows[i].item, directed_rows[i].typed,
                           directed_rows[i].emit, directed_rows[i].exp);
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_en = (p != NUM_PHASES - 1) && (p % 4 != 2);
            wait_drained();
            case (p)
                0: begin
                    dz_v = 0; lin_v = 32'h8000; ang_v = 32'h7FFF;
                    map_v = 0; dm_v = 0; ar_v = 1;
                end
                1: begin
                    dz_v = 32766; lin_v = 32'h7FFF; ang_v = 32'h8000;
                    map_v = 32'hFFF; dm_v = 15; ar_v = 0;
                end
                2: begin
                    dz_v = 32767; lin_v = 0; ang_v = 256;
                    map_v = $urandom_range(0, 4095); dm_v = 32'h10; ar_v = 1;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: dz_v = 0;
                        1: dz_v = 32767;
                        2: dz_v = 32766;
                        3: dz_v = $urandom_range(0, 4000);
                        default: dz_v = $urandom_range(0, 32767);
                    endcase
                    lin_v = ($urandom_range(0, 3) == 0) ? 32'd256 : $urandom_range(0, 65535);
                    ang_v = ($urandom_range(0, 3) == 0) ? 32'd256 : $urandom_range(0, 65535);
                    map_v = $urandom_range(0, 4095);
                    dm_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, BUTTON_CNT - 1);
                    ar_v  = (p == 3) ? 32'd1 : $urandom_range(0, 1);
                end
            endcase
            write_reg(REG_DEADZONE, dz_v);
            write_reg(REG_LINEAR_SCALE, lin_v);
            write_reg(REG_ANGULAR_SCALE, ang_v);
            write_reg(REG_AXIS_MAP, map_v);
            write_reg(REG_DEADMAN_BUTTON, dm_v);
            write_reg(REG_AUTOREPEAT, ar_v);

            // stall the output long enough for the block to back up its input
            if (p == 3) long_hold_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = random_item();
                drive_item(it, 1'b0, 1'b0, unused_exp);
            end
        end

        cmd_ch.valid <= 1'b0;
        while (vel_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0 && vel_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### joystick_to_velocity_mapper.f
sv/jvm_pkg.sv
sv/jvm_if.sv
sv/joystick_to_velocity_mapper.sv
verif/tb_joystick_to_velocity_mapper.sv
